// ===== rtl/cst_pkg.sv =====
// ---------------------------------------------------------------------------
// cst_pkg: shared types and constants for the C source tokenizer
// Payload structs, token kinds, counter widths and result bundle layout.
// ---------------------------------------------------------------------------
package cst_pkg;

  localparam int OFFSET_BITS = 24;
  localparam int LINE_BITS   = 20;
  localparam int COLUMN_BITS = 16;

  localparam int BUNDLE_MAX = 3;

  typedef enum logic [5:0] {
    K_INC, K_ADD_ASSIGN, K_ADD, K_DEC, K_SUB_ASSIGN, K_SUB, K_MUL_ASSIGN, K_MUL,
    K_DIV_ASSIGN, K_DIV, K_MOD_ASSIGN, K_MOD, K_EQ, K_ASSIGN, K_NE, K_NOT, K_LE,
    K_SHL_ASSIGN, K_SHL, K_LT, K_GE, K_SHR_ASSIGN, K_SHR, K_GT, K_AND,
    K_AND_ASSIGN, K_BIT_AND, K_OR, K_OR_ASSIGN, K_BIT_OR, K_XOR_ASSIGN, K_XOR,
    K_BIT_NOT, K_LPAREN, K_RPAREN, K_LBRACKET, K_RBRACKET, K_LBRACE, K_RBRACE,
    K_COMMA, K_SEMICOLON, K_COLON, K_QUESTION, K_STRING, K_CHAR, K_IDENTIFIER,
    K_HEX, K_FLOAT, K_INT, K_EOF
  } tk_t;

  localparam logic [2:0] E_NONE     = 3'd0;
  localparam logic [2:0] E_UNT_STR  = 3'd1;
  localparam logic [2:0] E_UNT_CHR  = 3'd2;
  localparam logic [2:0] E_CHR_MULT = 3'd3;
  localparam logic [2:0] E_BAD_NUM  = 3'd4;

  localparam logic RK_TOKEN = 1'b0;
  localparam logic RK_VALUE = 1'b1;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic        record_kind;
    logic [5:0]  token_kind;
    logic [23:0] start_offset;
    logic [15:0] token_length;
    logic [19:0] line_number;
    logic [15:0] column_number;
    logic [7:0]  value_byte;
    logic [2:0]  error_code;
    logic        last_of_run;
  } out_item_t;

  typedef struct packed {
    out_item_t [BUNDLE_MAX-1:0] recs;
    logic [1:0]                 cnt;
  } bundle_t;

  typedef struct packed {
    logic       full;
    logic       empty;
    logic [1:0] level;
  } q_status_t;

endpackage

// ===== rtl/cst_front.sv =====
// ---------------------------------------------------------------------------
// cst_front: lexer front end
// Tracks lexing mode and position, classifies each byte and builds the
// bundle of records that byte causes.
// ---------------------------------------------------------------------------
module cst_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  cst_pkg::in_item_t item,
  output logic              push,
  output cst_pkg::bundle_t  bundle
);

  typedef enum logic [9:0] {
    M_IDLE  = 10'b0000000001,
    M_OP    = 10'b0000000010,
    M_LINE  = 10'b0000000100,
    M_BLOCK = 10'b0000001000,
    M_STR   = 10'b0000010000,
    M_CHR   = 10'b0000100000,
    M_IDENT = 10'b0001000000,
    M_ZERO  = 10'b0010000000,
    M_HEX   = 10'b0100000000,
    M_NUM   = 10'b1000000000
  } mode_t;

  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_TAB = 8'h09;

  localparam int OB = cst_pkg::OFFSET_BITS;
  localparam int LB = cst_pkg::LINE_BITS;
  localparam int CB = cst_pkg::COLUMN_BITS;

  mode_t         mode_r, mode_nxt;
  logic [7:0]    p0_r, p0_nxt;
  logic          p1_r, p1_nxt;
  logic [OB-1:0] off_r, off_nxt, tso_r, tso_nxt;
  logic [LB-1:0] line_r, line_nxt, tsl_r, tsl_nxt;
  logic [CB-1:0] col_r, col_nxt, tsc_r, tsc_nxt;
  logic [15:0]   tl_r, tl_nxt;
  logic          es_r, es_nxt;
  logic [1:0]    dc_r, dc_nxt;

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic [7:0] decode(logic [7:0] c);
    case (c)
      "n":     return 8'd10;
      "r":     return 8'd13;
      "t":     return 8'd9;
      "b":     return 8'd8;
      "f":     return 8'd12;
      default: return c;
    endcase
  endfunction

  function automatic cst_pkg::tk_t op_single(logic [7:0] c);
    case (c)
      "+":     return cst_pkg::K_ADD;
      "-":     return cst_pkg::K_SUB;
      "*":     return cst_pkg::K_MUL;
      "/":     return cst_pkg::K_DIV;
      "%":     return cst_pkg::K_MOD;
      "=":     return cst_pkg::K_ASSIGN;
      "!":     return cst_pkg::K_NOT;
      "<":     return cst_pkg::K_LT;
      ">":     return cst_pkg::K_GT;
      "&":     return cst_pkg::K_BIT_AND;
      "|":     return cst_pkg::K_BIT_OR;
      default: return cst_pkg::K_XOR;
    endcase
  endfunction

  // {valid, kind} of a two-char operator
  function automatic logic [6:0] op_pair(logic [7:0] f, logic [7:0] c);
    cst_pkg::tk_t k;
    k = cst_pkg::K_XOR_ASSIGN;
    if (c == "=") begin
      case (f)
        "+":     k = cst_pkg::K_ADD_ASSIGN;
        "-":     k = cst_pkg::K_SUB_ASSIGN;
        "*":     k = cst_pkg::K_MUL_ASSIGN;
        "/":     k = cst_pkg::K_DIV_ASSIGN;
        "%":     k = cst_pkg::K_MOD_ASSIGN;
        "=":     k = cst_pkg::K_EQ;
        "!":     k = cst_pkg::K_NE;
        "<":     k = cst_pkg::K_LE;
        ">":     k = cst_pkg::K_GE;
        "&":     k = cst_pkg::K_AND_ASSIGN;
        "|":     k = cst_pkg::K_OR_ASSIGN;
        default: k = cst_pkg::K_XOR_ASSIGN;
      endcase
      return {1'b1, k};
    end
    if (c == f) begin
      case (f)
        "+":     return {1'b1, cst_pkg::K_INC};
        "-":     return {1'b1, cst_pkg::K_DEC};
        "&":     return {1'b1, cst_pkg::K_AND};
        "|":     return {1'b1, cst_pkg::K_OR};
        default: return {1'b0, k};
      endcase
    end
    return {1'b0, k};
  endfunction

  // {valid, kind} of a one-char token
  function automatic logic [6:0] single_kind(logic [7:0] c);
    case (c)
      "~":     return {1'b1, cst_pkg::K_BIT_NOT};
      "(":     return {1'b1, cst_pkg::K_LPAREN};
      ")":     return {1'b1, cst_pkg::K_RPAREN};
      "[":     return {1'b1, cst_pkg::K_LBRACKET};
      "]":     return {1'b1, cst_pkg::K_RBRACKET};
      "{":     return {1'b1, cst_pkg::K_LBRACE};
      "}":     return {1'b1, cst_pkg::K_RBRACE};
      ",":     return {1'b1, cst_pkg::K_COMMA};
      ";":     return {1'b1, cst_pkg::K_SEMICOLON};
      ":":     return {1'b1, cst_pkg::K_COLON};
      "?":     return {1'b1, cst_pkg::K_QUESTION};
      default: return {1'b0, cst_pkg::K_INC};
    endcase
  endfunction

  function automatic logic is_op(logic [7:0] c);
    return c == "+" || c == "-" || c == "*" || c == "/" || c == "%" || c == "=" ||
           c == "!" || c == "<" || c == ">" || c == "&" || c == "|" || c == "^";
  endfunction

  function automatic cst_pkg::out_item_t mk(logic rk, cst_pkg::tk_t k, logic [15:0] len,
                                            logic [7:0] vb, logic [2:0] err,
                                            logic [OB-1:0] so, logic [LB-1:0] sl,
                                            logic [CB-1:0] sc);
    cst_pkg::out_item_t r;
    r.record_kind   = rk;
    r.token_kind    = k;
    r.start_offset  = 24'(so);
    r.token_length  = len;
    r.line_number   = 20'(sl);
    r.column_number = 16'(sc);
    r.value_byte    = vb;
    r.error_code    = err;
    r.last_of_run   = 1'b0;
    return r;
  endfunction

  logic [7:0] c;
  logic       again, num_go, do_fin, do_idle;
  logic [6:0] pk, sk;
  cst_pkg::tk_t lk;
  logic [1:0] n;
  cst_pkg::out_item_t [cst_pkg::BUNDLE_MAX-1:0] recs;

  always_comb begin
    c        = item.char_byte;
    mode_nxt = mode_r;
    p0_nxt   = p0_r;
    p1_nxt   = p1_r;
    off_nxt  = off_r;
    line_nxt = line_r;
    col_nxt  = col_r;
    tso_nxt  = tso_r;
    tsl_nxt  = tsl_r;
    tsc_nxt  = tsc_r;
    tl_nxt   = tl_r;
    es_nxt   = es_r;
    dc_nxt   = dc_r;
    again    = 1'b0;
    num_go   = 1'b0;
    n        = 2'd0;
    recs     = '0;
    pk       = op_pair(p0_r, c);
    sk       = single_kind(c);
    lk       = (mode_r == M_CHR) ? cst_pkg::K_CHAR : cst_pkg::K_STRING;

    if (!item.end_of_input) begin
      case (mode_r)
        M_IDLE: ;
        M_OP: begin
          if (p1_r) begin
            if (c == "=") begin
              tl_nxt = (tl_nxt == '1) ? tl_nxt : tl_nxt + 16'd1;
              recs[n] = mk(cst_pkg::RK_TOKEN,
                           (p0_r == "<") ? cst_pkg::K_SHL_ASSIGN : cst_pkg::K_SHR_ASSIGN,
                           tl_nxt, 8'd0, cst_pkg::E_NONE, tso_nxt, tsl_nxt, tsc_nxt);
              n = n + 2'd1;
              p0_nxt = '0; p1_nxt = 1'b0; mode_nxt = M_IDLE;
            end else again = 1'b1;
          end else if (p0_r == "/" && c == "/") begin
            p0_nxt = '0; mode_nxt = M_LINE;
          end else if (p0_r == "/" && c == "*") begin
            p0_nxt = '0; es_nxt = 1'b0; mode_nxt = M_BLOCK;
          end else if ((p0_r == "<" || p0_r == ">") && c == p0_r) begin
            tl_nxt = (tl_nxt == '1) ? tl_nxt : tl_nxt + 16'd1;
            p1_nxt = 1'b1;
          end else if (pk[6]) begin
            tl_nxt = (tl_nxt == '1) ? tl_nxt : tl_nxt + 16'd1;
            recs[n] = mk(cst_pkg::RK_TOKEN, cst_pkg::tk_t'(pk[5:0]), tl_nxt, 8'd0,
                         cst_pkg::E_NONE, tso_nxt, tsl_nxt, tsc_nxt);
            n = n + 2'd1;
            p0_nxt = '0; mode_nxt = M_IDLE;
          end else again = 1'b1;
        end
        M_LINE: if (c == CH_LF) mode_nxt = M_IDLE;
        M_BLOCK: begin
          if (es_r && c == "/") begin
            es_nxt = 1'b0; mode_nxt = M_IDLE;
          end else es_nxt = (c == "*");
        end
        M_STR, M_CHR: begin
          if (es_r) begin
            tl_nxt = (tl_nxt == '1) ? tl_nxt : tl_nxt + 16'd1;
            es_nxt = 1'b0;
            if (dc_nxt != 2'd2) dc_nxt = dc_nxt + 2'd1;
            recs[n] = mk(cst_pkg::RK_VALUE, lk, 16'd0, decode(c), cst_pkg::E_NONE,
                         tso_nxt, tsl_nxt, tsc_nxt);
            n = n + 2'd1;
          end else if (c == "\\") begin
            tl_nxt = (tl_nxt == '1) ? tl_nxt : tl_nxt + 16'd1;
            es_nxt = 1'b1;
          end else if ((mode_r == M_STR && c == "\"") || (mode_r == M_CHR && c == "'")) begin
            tl_nxt = (tl_nxt == '1) ? tl_nxt : tl_nxt + 16'd1;
            recs[n] = mk(cst_pkg::RK_TOKEN, lk, tl_nxt, 8'd0,
                         (mode_r == M_CHR && dc_r != 2'd1) ? cst_pkg::E_CHR_MULT
                                                            : cst_pkg::E_NONE,
                         tso_nxt, tsl_nxt, tsc_nxt);
            n = n + 2'd1;
            mode_nxt = M_IDLE;
          end else if (c == CH_LF && mode_r == M_STR) begin
            again = 1'b1;
          end else begin
            tl_nxt = (tl_nxt == '1) ? tl_nxt : tl_nxt + 16'd1;
            if (dc_nxt != 2'd2) dc_nxt = dc_nxt + 2'd1;
            recs[n] = mk(cst_pkg::RK_VALUE, lk, 16'd0, c, cst_pkg::E_NONE,
                         tso_nxt, tsl_nxt, tsc_nxt);
            n = n + 2'd1;
          end
        end
        M_IDENT: begin
          if (is_alpha(c) || is_digit(c)) begin
            tl_nxt = (tl_nxt == '1) ? tl_nxt : tl_nxt + 16'd1;
            recs[n] = mk(cst_pkg::RK_VALUE, cst_pkg::K_IDENTIFIER, 16'd0, c,
                         cst_pkg::E_NONE, tso_nxt, tsl_nxt, tsc_nxt);
            n = n + 2'd1;
          end else again = 1'b1;
        end
        M_ZERO: begin
          if (c == "x" || c == "X") begin
            tl_nxt = (tl_nxt == '1) ? tl_nxt : tl_nxt + 16'd1;
            dc_nxt = 2'd0; mode_nxt = M_HEX;
          end else if (is_digit(c) || c == "." || c == "_") begin
            dc_nxt = 2'd0; mode_nxt = M_NUM;
            recs[n] = mk(cst_pkg::RK_VALUE, cst_pkg::K_INT, 16'd0, "0",
                         cst_pkg::E_NONE, tso_nxt, tsl_nxt, tsc_nxt);
            n = n + 2'd1;
            num_go = 1'b1;
          end else again = 1'b1;
        end
        M_HEX: begin
          if (is_hex(c)) begin
            tl_nxt = (tl_nxt == '1) ? tl_nxt : tl_nxt + 16'd1;
            dc_nxt = 2'd1;
            recs[n] = mk(cst_pkg::RK_VALUE, cst_pkg::K_HEX, 16'd0, c,
                         cst_pkg::E_NONE, tso_nxt, tsl_nxt, tsc_nxt);
            n = n + 2'd1;
          end else if (c == "_") begin
            tl_nxt = (tl_nxt == '1) ? tl_nxt : tl_nxt + 16'd1;
          end else again = 1'b1;
        end
        M_NUM: num_go = 1'b1;
        default: ;
      endcase

      if (num_go) begin
        if (is_digit(c)) begin
          tl_nxt = (tl_nxt == '1) ? tl_nxt : tl_nxt + 16'd1;
          recs[n] = mk(cst_pkg::RK_VALUE, (dc_nxt != 2'd0) ? cst_pkg::K_FLOAT : cst_pkg::K_INT,
                       16'd0, c, cst_pkg::E_NONE, tso_nxt, tsl_nxt, tsc_nxt);
          n = n + 2'd1;
        end else if (c == ".") begin
          tl_nxt = (tl_nxt == '1) ? tl_nxt : tl_nxt + 16'd1;
          if (dc_nxt != 2'd2) dc_nxt = dc_nxt + 2'd1;
          recs[n] = mk(cst_pkg::RK_VALUE, cst_pkg::K_FLOAT, 16'd0, c,
                       cst_pkg::E_NONE, tso_nxt, tsl_nxt, tsc_nxt);
          n = n + 2'd1;
        end else if (c == "_") begin
          tl_nxt = (tl_nxt == '1) ? tl_nxt : tl_nxt + 16'd1;
        end else again = 1'b1;
      end
    end

    do_fin  = item.end_of_input || again;
    do_idle = !item.end_of_input && (again || mode_r == M_IDLE);

    // flush the token under construction
    if (do_fin) begin
      case (mode_nxt)
        M_OP: begin
          recs[n] = mk(cst_pkg::RK_TOKEN,
                       p1_nxt ? ((p0_nxt == "<") ? cst_pkg::K_SHL : cst_pkg::K_SHR)
                              : op_single(p0_nxt),
                       tl_nxt, 8'd0, cst_pkg::E_NONE, tso_nxt, tsl_nxt, tsc_nxt);
          n = n + 2'd1;
        end
        M_STR, M_CHR: begin
          recs[n] = mk(cst_pkg::RK_TOKEN,
                       (mode_nxt == M_CHR) ? cst_pkg::K_CHAR : cst_pkg::K_STRING,
                       tl_nxt, 8'd0,
                       (mode_nxt == M_CHR) ? cst_pkg::E_UNT_CHR : cst_pkg::E_UNT_STR,
                       tso_nxt, tsl_nxt, tsc_nxt);
          n = n + 2'd1;
        end
        M_IDENT: begin
          recs[n] = mk(cst_pkg::RK_TOKEN, cst_pkg::K_IDENTIFIER, tl_nxt, 8'd0,
                       cst_pkg::E_NONE, tso_nxt, tsl_nxt, tsc_nxt);
          n = n + 2'd1;
        end
        M_ZERO: begin
          recs[n] = mk(cst_pkg::RK_VALUE, cst_pkg::K_INT, 16'd0, "0",
                       cst_pkg::E_NONE, tso_nxt, tsl_nxt, tsc_nxt);
          n = n + 2'd1;
          recs[n] = mk(cst_pkg::RK_TOKEN, cst_pkg::K_INT, tl_nxt, 8'd0,
                       cst_pkg::E_NONE, tso_nxt, tsl_nxt, tsc_nxt);
          n = n + 2'd1;
        end
        M_HEX: begin
          recs[n] = mk(cst_pkg::RK_TOKEN, cst_pkg::K_HEX, tl_nxt, 8'd0,
                       (dc_nxt != 2'd0) ? cst_pkg::E_NONE : cst_pkg::E_BAD_NUM,
                       tso_nxt, tsl_nxt, tsc_nxt);
          n = n + 2'd1;
        end
        M_NUM: begin
          recs[n] = mk(cst_pkg::RK_TOKEN,
                       (dc_nxt != 2'd0) ? cst_pkg::K_FLOAT : cst_pkg::K_INT, tl_nxt, 8'd0,
                       (dc_nxt == 2'd2) ? cst_pkg::E_BAD_NUM : cst_pkg::E_NONE,
                       tso_nxt, tsl_nxt, tsc_nxt);
          n = n + 2'd1;
        end
        default: ;
      endcase
      p0_nxt   = '0;
      p1_nxt   = 1'b0;
      mode_nxt = M_IDLE;
    end

    // start of a new token
    if (do_idle) begin
      mode_nxt = M_IDLE;
      if (c != " " && c != CH_TAB && c != CH_CR && c != CH_LF &&
          (is_op(c) || sk[6] || c == "\"" || c == "'" || is_alpha(c) || is_digit(c))) begin
        tso_nxt = off_r;
        tsl_nxt = line_r;
        tsc_nxt = col_r;
        tl_nxt  = 16'd1;
      end
      if (is_op(c)) begin
        p0_nxt = c; mode_nxt = M_OP;
      end else if (sk[6]) begin
        recs[n] = mk(cst_pkg::RK_TOKEN, cst_pkg::tk_t'(sk[5:0]), tl_nxt, 8'd0,
                     cst_pkg::E_NONE, tso_nxt, tsl_nxt, tsc_nxt);
        n = n + 2'd1;
      end else if (c == "\"") begin
        es_nxt = 1'b0; mode_nxt = M_STR;
      end else if (c == "'") begin
        es_nxt = 1'b0; dc_nxt = 2'd0; mode_nxt = M_CHR;
      end else if (is_alpha(c)) begin
        mode_nxt = M_IDENT;
        recs[n] = mk(cst_pkg::RK_VALUE, cst_pkg::K_IDENTIFIER, 16'd0, c,
                     cst_pkg::E_NONE, tso_nxt, tsl_nxt, tsc_nxt);
        n = n + 2'd1;
      end else if (c == "0") begin
        mode_nxt = M_ZERO;
      end else if (is_digit(c)) begin
        dc_nxt = 2'd0; mode_nxt = M_NUM;
        recs[n] = mk(cst_pkg::RK_VALUE, cst_pkg::K_INT, 16'd0, c,
                     cst_pkg::E_NONE, tso_nxt, tsl_nxt, tsc_nxt);
        n = n + 2'd1;
      end
    end

    if (item.end_of_input) begin
      recs[n] = mk(cst_pkg::RK_TOKEN, cst_pkg::K_EOF, 16'd0, 8'd0, cst_pkg::E_NONE,
                   off_r, line_r, col_r);
      n = n + 2'd1;
      mode_nxt = M_IDLE;
      p0_nxt   = '0;
      p1_nxt   = 1'b0;
      off_nxt  = '0;
      line_nxt = LB'(1);
      col_nxt  = CB'(1);
      tso_nxt  = '0;
      tsl_nxt  = LB'(1);
      tsc_nxt  = CB'(1);
      tl_nxt   = '0;
      es_nxt   = 1'b0;
      dc_nxt   = 2'd0;
    end else begin
      off_nxt = (off_r == '1) ? off_r : off_r + OB'(1);
      if (c == CH_LF) begin
        line_nxt = (line_r == '1) ? line_r : line_r + LB'(1);
        col_nxt  = CB'(1);
      end else begin
        col_nxt  = (col_r == '1) ? col_r : col_r + CB'(1);
      end
    end
  end

  assign push        = acc && (n != 2'd0);
  assign bundle.recs = recs;
  assign bundle.cnt  = n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      p0_r   <= '0;
      p1_r   <= 1'b0;
      off_r  <= '0;
      line_r <= LB'(1);
      col_r  <= CB'(1);
      tso_r  <= '0;
      tsl_r  <= LB'(1);
      tsc_r  <= CB'(1);
      tl_r   <= '0;
      es_r   <= 1'b0;
      dc_r   <= 2'd0;
    end else if (acc) begin
      mode_r <= mode_nxt;
      p0_r   <= p0_nxt;
      p1_r   <= p1_nxt;
      off_r  <= off_nxt;
      line_r <= line_nxt;
      col_r  <= col_nxt;
      tso_r  <= tso_nxt;
      tsl_r  <= tsl_nxt;
      tsc_r  <= tsc_nxt;
      tl_r   <= tl_nxt;
      es_r   <= es_nxt;
      dc_r   <= dc_nxt;
    end
  end

endmodule

// ===== rtl/cst_queue.sv =====
// ---------------------------------------------------------------------------
// cst_queue: two-entry bundle queue
// Decouples the lexer front end from the record emitter.
// ---------------------------------------------------------------------------
module cst_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  cst_pkg::bundle_t   wr_data,
  input  logic               pop,
  output cst_pkg::bundle_t   head,
  output cst_pkg::q_status_t status
);

  cst_pkg::bundle_t ent_r [2];
  logic             wp_r, rp_r;
  logic [1:0]       lvl_r, lvl_nxt;

  always_comb begin
    lvl_nxt = lvl_r;
    if (push && !pop) lvl_nxt = lvl_r + 2'd1;
    if (pop && !push) lvl_nxt = lvl_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      lvl_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      lvl_r <= lvl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= wr_data;
  end

  assign head         = ent_r[rp_r];
  assign status.full  = (lvl_r == 2'd2);
  assign status.empty = (lvl_r == 2'd0);
  assign status.level = lvl_r;

endmodule

// ===== rtl/cst_emit.sv =====
// ---------------------------------------------------------------------------
// cst_emit: record emitter
// Walks the head bundle one record per accepted output and marks the last.
// ---------------------------------------------------------------------------
module cst_emit (
  input  logic               clk,
  input  logic               rst_n,
  input  cst_pkg::bundle_t   head,
  input  logic               empty,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output cst_pkg::out_item_t out_data
);

  logic [1:0] idx_r;
  logic       last;

  assign out_valid = !empty;
  assign last      = (idx_r == head.cnt - 2'd1);
  assign pop       = out_valid && !out_stall && last;

  always_comb begin
    out_data             = head.recs[idx_r];
    out_data.last_of_run = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else if (out_valid && !out_stall) begin
      idx_r <= last ? 2'd0 : idx_r + 2'd1;
    end
  end

endmodule

// ===== rtl/c_source_tokenizer.sv =====
// ---------------------------------------------------------------------------
// c_source_tokenizer: C source lexer
// Byte stream in, token and decoded value records out.
//
//   channel | dir | handshake            | payload
//   in_     | in  | in_valid / in_stall   | in_item_t  (char_byte, end_of_input)
//   out_    | out | out_valid / out_stall | out_item_t (token record or value byte)
//
// One byte accepted per cycle unless the queue is full; lexer state is registered.
// Each byte yields up to three records (four never occur), sent one per cycle
// while out_stall is low from a two-entry bundle queue, so output rate sets
// the sustained throughput. Synchronous active-low reset clears mode,
// counters and the queue. in_stall rises only while the queue is full.
// ---------------------------------------------------------------------------
module c_source_tokenizer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cst_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output cst_pkg::out_item_t out_data
);

  logic               acc, push, pop;
  cst_pkg::bundle_t   wr_bundle, head;
  cst_pkg::q_status_t q_st;

  assign in_stall = q_st.full;
  assign acc      = in_valid && !in_stall;

  cst_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .acc    (acc),
    .item   (in_data),
    .push   (push),
    .bundle (wr_bundle)
  );

  cst_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (wr_bundle),
    .pop     (pop),
    .head    (head),
    .status  (q_st)
  );

  cst_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .empty     (q_st.empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_eof_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.end_of_input) |=> out_valid)
    else $error("EOF item produced no queued record");

  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.record_kind == cst_pkg::RK_TOKEN &&
     out_data.token_kind == cst_pkg::K_EOF) |-> out_data.last_of_run)
    else $error("EOF record not last of its run");

  a_value_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.record_kind == cst_pkg::RK_VALUE) |->
      (out_data.token_length == 16'd0 && out_data.error_code == cst_pkg::E_NONE))
    else $error("value record carries length or error");

endmodule

// ===== bench/tb.sv =====
// ---------------------------------------------------------------------------
// tb: C source tokenizer regression
// Drives byte and end-marker items through the tokenizer and compares every
// token and value record against a behavioral lexer model kept in the bench.
// A directed table covers operators, comments, literals, numbers and errors;
// random source fragments and noise bytes follow.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [3:0] {
    LM_IDLE, LM_OP, LM_LINE, LM_BLOCK, LM_STR, LM_CHR, LM_IDENT, LM_ZERO, LM_HEX, LM_NUM
  } lmode_t;

  logic clk, rst_n, in_valid, in_stall, out_valid, out_stall;
  cst_pkg::in_item_t in_data;
  cst_pkg::out_item_t out_data;

  c_source_tokenizer dut (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // lexer model state
  lmode_t lm;
  logic [15:0] pend;
  logic [19:0] cur_line, st_line;
  logic [15:0] cur_col, st_col, tlen;
  logic [23:0] boff, st_off;
  logic esc_star;
  logic [1:0] dots;

  cst_pkg::out_item_t rec_q[$];
  int nstep;
  cst_pkg::out_item_t step_recs[4];
  int fails = 0;
  bit quiet = 0;

  function automatic void lex_clear();
    lm = LM_IDLE; pend = 0; cur_line = 1; cur_col = 1; boff = 0;
    st_off = 0; st_line = 1; st_col = 1; tlen = 0; esc_star = 0; dots = 0;
  endfunction

  function automatic void put(logic rk, cst_pkg::tk_t k, logic [15:0] len, logic [7:0] vb,
                              logic [2:0] err);
    cst_pkg::out_item_t r;
    if (nstep >= 4) return;
    r.record_kind = rk; r.token_kind = k; r.start_offset = st_off;
    r.token_length = len; r.line_number = st_line; r.column_number = st_col;
    r.value_byte = vb; r.error_code = err; r.last_of_run = 0;
    step_recs[nstep] = r;
    nstep++;
  endfunction

  function automatic void put_tok(cst_pkg::tk_t k, logic [2:0] e);
    put(cst_pkg::RK_TOKEN, k, tlen, 0, e);
  endfunction
  function automatic void put_val(cst_pkg::tk_t k, logic [7:0] c);
    put(cst_pkg::RK_VALUE, k, 0, c, cst_pkg::E_NONE);
  endfunction
  function automatic void grow(); if (tlen != 16'hFFFF) tlen++; endfunction
  function automatic void start_tok(); st_off = boff; st_line = cur_line; st_col = cur_col;
    tlen = 1; endfunction
  function automatic bit is_al(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction
  function automatic bit is_dg(logic [7:0] c); return c >= "0" && c <= "9"; endfunction
  function automatic bit is_hx(logic [7:0] c);
    return is_dg(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction
  function automatic logic [7:0] unescape(logic [7:0] c);
    case (c)
      "n": return 8'd10;
      "r": return 8'd13;
      "t": return 8'd9;
      "b": return 8'd8;
      "f": return 8'd12;
      default: return c;
    endcase
  endfunction

  function automatic cst_pkg::tk_t single_op(logic [7:0] c);
    case (c)
      "+": return cst_pkg::K_ADD;     "-": return cst_pkg::K_SUB;
      "*": return cst_pkg::K_MUL;     "/": return cst_pkg::K_DIV;
      "%": return cst_pkg::K_MOD;     "=": return cst_pkg::K_ASSIGN;
      "!": return cst_pkg::K_NOT;     "<": return cst_pkg::K_LT;
      ">": return cst_pkg::K_GT;      "&": return cst_pkg::K_BIT_AND;
      "|": return cst_pkg::K_BIT_OR;
      default: return cst_pkg::K_XOR;
    endcase
  endfunction

  function automatic int pair_op(logic [7:0] f, logic [7:0] c);
    if (c == "=") begin
      case (f)
        "+": return cst_pkg::K_ADD_ASSIGN; "-": return cst_pkg::K_SUB_ASSIGN;
        "*": return cst_pkg::K_MUL_ASSIGN; "/": return cst_pkg::K_DIV_ASSIGN;
        "%": return cst_pkg::K_MOD_ASSIGN; "=": return cst_pkg::K_EQ;
        "!": return cst_pkg::K_NE; "<": return cst_pkg::K_LE; ">": return cst_pkg::K_GE;
        "&": return cst_pkg::K_AND_ASSIGN; "|": return cst_pkg::K_OR_ASSIGN;
        default: return cst_pkg::K_XOR_ASSIGN;
      endcase
    end
    if (c == f) begin
      if (f == "+") return cst_pkg::K_INC;
      if (f == "-") return cst_pkg::K_DEC;
      if (f == "&") return cst_pkg::K_AND;
      if (f == "|") return cst_pkg::K_OR;
    end
    return -1;
  endfunction

  function automatic void from_idle(logic [7:0] c);
    lm = LM_IDLE;
    case (c)
      " ", "\t", 8'd13, "\n": return;
      "+", "-", "*", "/", "%", "=", "!", "<", ">", "&", "|", "^": begin
        start_tok(); pend = {8'd0, c}; lm = LM_OP; return;
      end
      "~": begin start_tok(); put_tok(cst_pkg::K_BIT_NOT, cst_pkg::E_NONE); return; end
      "(": begin start_tok(); put_tok(cst_pkg::K_LPAREN, cst_pkg::E_NONE); return; end
      ")": begin start_tok(); put_tok(cst_pkg::K_RPAREN, cst_pkg::E_NONE); return; end
      "[": begin start_tok(); put_tok(cst_pkg::K_LBRACKET, cst_pkg::E_NONE); return; end
      "]": begin start_tok(); put_tok(cst_pkg::K_RBRACKET, cst_pkg::E_NONE); return; end
      "{": begin start_tok(); put_tok(cst_pkg::K_LBRACE, cst_pkg::E_NONE); return; end
      "}": begin start_tok(); put_tok(cst_pkg::K_RBRACE, cst_pkg::E_NONE); return; end
      ",": begin start_tok(); put_tok(cst_pkg::K_COMMA, cst_pkg::E_NONE); return; end
      ";": begin start_tok(); put_tok(cst_pkg::K_SEMICOLON, cst_pkg::E_NONE); return; end
      ":": begin start_tok(); put_tok(cst_pkg::K_COLON, cst_pkg::E_NONE); return; end
      "?": begin start_tok(); put_tok(cst_pkg::K_QUESTION, cst_pkg::E_NONE); return; end
      "\"": begin start_tok(); esc_star = 0; lm = LM_STR; return; end
      "'": begin start_tok(); esc_star = 0; dots = 0; lm = LM_CHR; return; end
      default: ;
    endcase
    if (is_al(c)) begin
      start_tok(); lm = LM_IDENT; put_val(cst_pkg::K_IDENTIFIER, c);
    end else if (c == "0") begin
      start_tok(); lm = LM_ZERO;
    end else if (is_dg(c)) begin
      start_tok(); dots = 0; lm = LM_NUM; put_val(cst_pkg::K_INT, c);
    end
  endfunction

  function automatic void flush_tok();
    logic [7:0] f;
    f = pend[7:0];
    case (lm)
      LM_OP: begin
        if (pend[15:8] != 0)
          put_tok(f == "<" ? cst_pkg::K_SHL : cst_pkg::K_SHR, cst_pkg::E_NONE);
        else put_tok(single_op(f), cst_pkg::E_NONE);
      end
      LM_STR: put_tok(cst_pkg::K_STRING, cst_pkg::E_UNT_STR);
      LM_CHR: put_tok(cst_pkg::K_CHAR, cst_pkg::E_UNT_CHR);
      LM_IDENT: put_tok(cst_pkg::K_IDENTIFIER, cst_pkg::E_NONE);
      LM_ZERO: begin
        put_val(cst_pkg::K_INT, "0"); put_tok(cst_pkg::K_INT, cst_pkg::E_NONE);
      end
      LM_HEX: put_tok(cst_pkg::K_HEX, dots != 0 ? cst_pkg::E_NONE : cst_pkg::E_BAD_NUM);
      LM_NUM: put_tok(dots != 0 ? cst_pkg::K_FLOAT : cst_pkg::K_INT,
                      dots >= 2 ? cst_pkg::E_BAD_NUM : cst_pkg::E_NONE);
      default: ;
    endcase
    pend = 0;
    lm = LM_IDLE;
  endfunction

  function automatic bit num_char(logic [7:0] c);
    if (is_dg(c)) begin
      grow(); put_val(dots != 0 ? cst_pkg::K_FLOAT : cst_pkg::K_INT, c); return 0;
    end
    if (c == ".") begin
      grow(); if (dots < 2) dots++; put_val(cst_pkg::K_FLOAT, c); return 0;
    end
    if (c == "_") begin grow(); return 0; end
    return 1;
  endfunction

  function automatic bit lit_char(logic [7:0] c, logic [7:0] q, cst_pkg::tk_t k);
    if (esc_star) begin
      grow(); esc_star = 0; if (dots < 2) dots++; put_val(k, unescape(c));
    end else if (c == "\\") begin
      grow(); esc_star = 1;
    end else if (c == q) begin
      grow();
      put_tok(k, (k == cst_pkg::K_CHAR && dots != 1) ? cst_pkg::E_CHR_MULT : cst_pkg::E_NONE);
      lm = LM_IDLE;
    end else if (c == "\n" && k == cst_pkg::K_STRING) begin
      return 1;
    end else begin
      grow(); if (dots < 2) dots++; put_val(k, c);
    end
    return 0;
  endfunction

  function automatic void lex_char(logic [7:0] c);
    bit redo;
    logic [7:0] f;
    int k;
    redo = 0;
    f = pend[7:0];
    case (lm)
      LM_IDLE: begin from_idle(c); return; end
      LM_OP: begin
        if (pend[15:8] != 0) begin
          if (c == "=") begin
            grow();
            put_tok(f == "<" ? cst_pkg::K_SHL_ASSIGN : cst_pkg::K_SHR_ASSIGN, cst_pkg::E_NONE);
            pend = 0; lm = LM_IDLE;
          end else redo = 1;
        end else if (f == "/" && c == "/") begin
          pend = 0; lm = LM_LINE;
        end else if (f == "/" && c == "*") begin
          pend = 0; esc_star = 0; lm = LM_BLOCK;
        end else if ((f == "<" || f == ">") && c == f) begin
          grow(); pend = {c, f};
        end else begin
          k = pair_op(f, c);
          if (k >= 0) begin
            grow(); put_tok(cst_pkg::tk_t'(k), cst_pkg::E_NONE); pend = 0; lm = LM_IDLE;
          end else redo = 1;
        end
      end
      LM_LINE: begin if (c == "\n") lm = LM_IDLE; return; end
      LM_BLOCK: begin
        if (esc_star && c == "/") begin esc_star = 0; lm = LM_IDLE; end
        else esc_star = (c == "*");
        return;
      end
      LM_STR: redo = lit_char(c, "\"", cst_pkg::K_STRING);
      LM_CHR: redo = lit_char(c, "'", cst_pkg::K_CHAR);
      LM_IDENT: begin
        if (is_al(c) || is_dg(c)) begin grow(); put_val(cst_pkg::K_IDENTIFIER, c); end
        else redo = 1;
      end
      LM_ZERO: begin
        if (c == "x" || c == "X") begin
          grow(); dots = 0; lm = LM_HEX;
        end else if (is_dg(c) || c == "." || c == "_") begin
          dots = 0; lm = LM_NUM; put_val(cst_pkg::K_INT, "0"); void'(num_char(c));
        end else redo = 1;
      end
      LM_HEX: begin
        if (is_hx(c)) begin grow(); dots = 1; put_val(cst_pkg::K_HEX, c); end
        else if (c == "_") grow();
        else redo = 1;
      end
      LM_NUM: redo = num_char(c);
      default: begin from_idle(c); return; end
    endcase
    if (redo) begin flush_tok(); from_idle(c); end
  endfunction

  // push expected records for one accepted item
  function automatic void lex_item(cst_pkg::in_item_t it);
    nstep = 0;
    if (it.end_of_input) begin
      flush_tok();
      st_off = boff; st_line = cur_line; st_col = cur_col; tlen = 0;
      put_tok(cst_pkg::K_EOF, cst_pkg::E_NONE);
      lex_clear();
    end else begin
      lex_char(it.char_byte);
      if (boff != '1) boff++;
      if (it.char_byte == "\n") begin
        if (cur_line != '1) cur_line++;
        cur_col = 1;
      end else if (cur_col != '1) cur_col++;
    end
    if (nstep > 0) step_recs[nstep-1].last_of_run = 1;
    for (int i = 0; i < nstep; i++) rec_q.push_back(step_recs[i]);
  endfunction

  // directed table: byte, eoi, typed check (kind/err of the last record of the step)
  typedef struct {
    logic [7:0] ch;
    logic eoi;
    bit typed;
    cst_pkg::tk_t kind;
    logic [2:0] err;
  } row_t;

  row_t dir_tbl[$];
  function automatic void row(logic [7:0] c, logic e = 0);
    dir_tbl.push_back('{c, e, 0, cst_pkg::K_EOF, cst_pkg::E_NONE});
  endfunction
  function automatic void row_chk(logic [7:0] c, logic e, cst_pkg::tk_t k, logic [2:0] er);
    dir_tbl.push_back('{c, e, 1, k, er});
  endfunction
  function automatic void row_str(string s);
    for (int i = 0; i < s.len(); i++) row(s[i]);
  endfunction

  // typed expectations from the table are checked on the last record of a step
  cst_pkg::tk_t tkind_q[$];
  logic [2:0] terr_q[$];
  bit tflag_q[$];

  always @(posedge clk) begin
    cst_pkg::out_item_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (rec_q.size() == 0) begin
        $display("%0t unexpected record: expected none, actual %p", $time, out_data);
        fails++;
      end else begin
        e = rec_q.pop_front();
        if (out_data !== e) begin
          $display("%0t mismatch: expected %p, actual %p", $time, e, out_data);
          fails++;
        end
        if (e.last_of_run && tflag_q.size() > 0) begin
          if (tflag_q[0] && (out_data.token_kind !== tkind_q[0] ||
                             out_data.error_code !== terr_q[0])) begin
            $display("%0t table mismatch: expected kind %s err %0d, actual kind %0d err %0d",
                     $time, tkind_q[0].name(), terr_q[0], out_data.token_kind,
                     out_data.error_code);
            fails++;
          end
          void'(tflag_q.pop_front()); void'(tkind_q.pop_front());
          void'(terr_q.pop_front());
        end
      end
    end
  end

  // receiver stalls
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_stall <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= (stall_left > 1);
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 4);
      out_stall <= 1;
    end else begin
      out_stall <= 0;
    end
  end

  // watchdog
  int idle_cyc = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cyc <= 0;
    else idle_cyc <= idle_cyc + 1;
    if (idle_cyc > 5000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send(cst_pkg::in_item_t it, bit typed, cst_pkg::tk_t k, logic [2:0] er);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_data <= it;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    lex_item(it);
    if (nstep > 0) begin
      tflag_q.push_back(typed); tkind_q.push_back(k); terr_q.push_back(er);
    end
  endtask

  task automatic send_char(logic [7:0] c);
    cst_pkg::in_item_t it;
    it.char_byte = c; it.end_of_input = 0;
    send(it, 0, cst_pkg::K_EOF, cst_pkg::E_NONE);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  function automatic string rand_frag();
    string ops[$] = '{"+", "-", "*", "/", "%", "=", "!", "<", ">", "&", "|", "^",
                      "++", "+=", "--", "-=", "*=", "**", "/=", "%=", "==", "!=", "<=",
                      "<<", "<<=", ">>", ">>=", ">=", "&&", "&=", "||", "|=", "^=", "~",
                      "(", ")", "[", "]", "{", "}", ",", ";", ":", "?"};
    string s;
    int n;
    case ($urandom_range(0, 9))
      0, 1: return ops[$urandom_range(0, ops.size()-1)];
      2: begin
        s = "";
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++) s = $sformatf("%s%c", s, 8'(97 + $urandom_range(0, 25)));
        return {s, "_9"};
      end
      3: return $sformatf("%0d", $urandom_range(0, 99999));
      4: return $urandom_range(0, 1) ? "0x1_fA" : "0X";
      5: return $urandom_range(0, 1) ? "3.14" : "1.2.3";
      6: return $urandom_range(0, 1) ? "\"ab\\n\\\"c\"" : "\"x\ny";
      7: return $urandom_range(0, 2) == 0 ? "'ab'" : ($urandom_range(0, 1) ? "'\\t'" : "''");
      8: return $urandom_range(0, 1) ? "/* a ** b */" : "// note\n";
      default: return $urandom_range(0, 1) ? " " : "\n\t";
    endcase
  endfunction

  initial begin
    cst_pkg::in_item_t it;
    int start_rand;
    bit drained;
    lex_clear();
    rst_n = 0; in_valid = 0; in_data = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    row_chk("~", 0, cst_pkg::K_BIT_NOT, cst_pkg::E_NONE);
    row_str("<<= >> ** *= /*x**/ ");
    row_str("0x");
    row_chk(" ", 0, cst_pkg::K_HEX, cst_pkg::E_BAD_NUM);
    row_str("1.2.");
    row_chk(";", 0, cst_pkg::K_SEMICOLON, cst_pkg::E_NONE);
    row_str("\"a\\");
    row("\n");
    row_chk(8'hFF, 1, cst_pkg::K_EOF, cst_pkg::E_NONE);
    row_str("'ab'");
    row_chk(8'h00, 1, cst_pkg::K_EOF, cst_pkg::E_NONE);
    foreach (dir_tbl[i]) begin
      it.char_byte = dir_tbl[i].ch; it.end_of_input = dir_tbl[i].eoi;
      send(it, dir_tbl[i].typed, dir_tbl[i].kind, dir_tbl[i].err);
    end

    // random source fragments, noise and end markers
    start_rand = 0;
    drained = 0;
    while (start_rand < 160) begin
      if (!drained && start_rand >= 80) begin
        drained = 1;
        in_valid <= 0;
        while (rec_q.size() != 0) @(posedge clk);
      end
      if (start_rand >= 130) quiet = 1;
      case ($urandom_range(0, 19))
        0: begin
          it.char_byte = $urandom; it.end_of_input = 1;
          send(it, 0, cst_pkg::K_EOF, cst_pkg::E_NONE);
          start_rand++;
        end
        1, 2: begin send_char($urandom); start_rand++; end
        default: begin
          string s;
          s = rand_frag();
          send_text(s);
          send_char(" ");
          start_rand += s.len() + 1;
        end
      endcase
    end
    it.char_byte = 8'h00; it.end_of_input = 1;
    send(it, 0, cst_pkg::K_EOF, cst_pkg::E_NONE);
    in_valid <= 0;

    while (rec_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fails == 0 && rec_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

// ===== c_source_tokenizer.f =====
rtl/cst_pkg.sv
rtl/cst_front.sv
rtl/cst_queue.sv
rtl/cst_emit.sv
rtl/c_source_tokenizer.sv
bench/tb.sv
